// ===== design/cspl_pkg.sv =====
// cspl_pkg: widths, field offsets, codes and fixed-point helpers
// for the cubic spline evaluator; no dependencies
`timescale 1ns / 1ps

package cspl_pkg;

  // table geometry
  localparam int MAX_KNOTS = 64;
  localparam int IDX_W     = $clog2(MAX_KNOTS);
  localparam int CNT_W     = $clog2(MAX_KNOTS + 1);
  localparam int MIN_KNOTS = 2;
  localparam int CNT_RESET = 2;

  // value widths, signed Q16.16
  localparam int COORD_W  = 32;
  localparam int VALUE_W  = 32;
  localparam int RESULT_W = 32;
  localparam int FRAC_W   = 16;
  localparam int H_W      = COORD_W + 1;
  localparam int PROD_W   = VALUE_W + H_W;
  localparam int WIDE_W   = PROD_W + 1;
  localparam int COEF_W   = 4 * VALUE_W;

  // constant multiples used by the derivative forms, and a unit step
  localparam int ONE_MUL   = 1;
  localparam int D1_D_MUL  = 3;
  localparam int D1_C_MUL  = 2;
  localparam int D2_D_MUL  = 6;

  // input tdata layout, lowest field first
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_KNOT_LSB  = IN_IDX_LSB + IDX_W;
  localparam int IN_A_LSB     = IN_KNOT_LSB + COORD_W;
  localparam int IN_B_LSB     = IN_A_LSB + VALUE_W;
  localparam int IN_C_LSB     = IN_B_LSB + VALUE_W;
  localparam int IN_D_LSB     = IN_C_LSB + VALUE_W;
  localparam int IN_Q_LSB     = IN_D_LSB + VALUE_W;
  localparam int IN_DRV_LSB   = IN_Q_LSB + COORD_W;
  localparam int DRV_W        = 2;
  localparam int IN_FIELDS_W  = IN_DRV_LSB + DRV_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_FIELDS_W = RESULT_W + IDX_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // item kinds carried in in_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [DRV_W-1:0] {
    DRV_VALUE  = 2'd0,
    DRV_FIRST  = 2'd1,
    DRV_SECOND = 2'd2,
    DRV_NONE   = 2'd3
  } deriv_t;

  typedef struct packed {
    logic signed [WIDE_W-1:0] val;
    logic                     clip;
  } sat_t;

  // sign extend a table value to the wide working width
  function automatic logic signed [WIDE_W-1:0] widen(input logic signed [VALUE_W-1:0] v);
    widen = $signed({{(WIDE_W - VALUE_W){v[VALUE_W-1]}}, v});
  endfunction

  // clamp to w signed bits, flag when clipped
  function automatic sat_t sat_to(input logic signed [WIDE_W-1:0] v, input int w);
    logic signed [WIDE_W-1:0] mx;
    logic signed [WIDE_W-1:0] mn;
    sat_t r;
    mx = (WIDE_W'(1) <<< (w - 1)) - WIDE_W'(1);
    mn = -mx - WIDE_W'(1);
    r.val  = v;
    r.clip = 1'b0;
    if (v > mx) begin
      r.val  = mx;
      r.clip = 1'b1;
    end else if (v < mn) begin
      r.val  = mn;
      r.clip = 1'b1;
    end
    return r;
  endfunction

  // drop the fraction of a Q32 product, nearest with ties away from zero
  function automatic logic signed [WIDE_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
    logic signed [WIDE_W-1:0] e;
    e = $signed({p[PROD_W-1], p})
        + (WIDE_W'(1) <<< (FRAC_W - 1))
        - $signed({{(WIDE_W - 1){1'b0}}, p[PROD_W-1]});
    return e >>> FRAC_W;
  endfunction

endpackage

// ===== design/cspl_ram.sv =====
// cspl_ram: generic single-write, single-read synchronous ram
// registered read data, no dependencies
`timescale 1ns / 1ps

module cspl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cubic_spline_evaluator.sv =====
// cubic_spline_evaluator: knot table, binary segment search and Horner evaluation
// depends on cspl_pkg and cspl_ram
`timescale 1ns / 1ps
//
//  channel  direction  tdata (low bit up)                          tuser
//  in_      slave      entry_index knot_x coef_a..d query_x deriv  op
//  out_     master     result_value segment, zero pad              saturated
//  cfg_     write      knot_count                                  -
//
// a load item writes the knot and coefficient rams. an evaluate item runs, in order: accept,
// 2 bound reads, the search reads (at least 1), pick, coefficient read, then a multiply,
// round and add per Horner round (3, 2, 1 or 0 rounds), and done; a query outside the
// knots skips search and pick. the steps run one after another through the single read
// port of the knot ram and the one shared multiplier. reset clears control only,
// knot_count comes up as 2; the rams need no clearing. a result waits in the output
// register while the next item is accepted; a full one holds done.

module cubic_spline_evaluator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // entry_index, knot_x, coef_a, coef_b, coef_c, coef_d, query_x, deriv_order
  input  logic [cspl_pkg::IN_DATA_W-1:0]      in_tdata,
  // op
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_value, segment, zero pad
  output logic [cspl_pkg::OUT_DATA_W-1:0]     out_tdata,
  // saturated
  output logic                                out_tuser,
  input  logic                                cfg_we,
  input  logic [cspl_pkg::CNT_W-1:0]          cfg_wdata
);

  import cspl_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_FIRST  = 10'b00_0000_0010,
    S_LAST   = 10'b00_0000_0100,
    S_SEARCH = 10'b00_0000_1000,
    S_PICK   = 10'b00_0001_0000,
    S_COEF   = 10'b00_0010_0000,
    S_MUL    = 10'b00_0100_0000,
    S_RND    = 10'b00_1000_0000,
    S_ADD    = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           knot_count_r;
  logic signed [COORD_W-1:0]  q_r, q_nxt;
  deriv_t                     deriv_r, deriv_nxt;
  logic signed [COORD_W-1:0]  k0_r, k0_nxt;
  logic [IDX_W-1:0]           lo_r, lo_nxt, up_r, up_nxt, mid_r, mid_nxt;
  logic [IDX_W-1:0]           seg_r, seg_nxt;
  logic signed [H_W-1:0]      h_r, h_nxt;
  logic signed [VALUE_W-1:0]  t_r, t_nxt;
  logic signed [VALUE_W-1:0]  add0_r, add0_nxt, add1_r, add1_nxt, add2_r, add2_nxt;
  logic [1:0]                 rounds_r, rounds_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [VALUE_W-1:0]  rnd_r, rnd_nxt;
  logic                       clip_r, clip_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [RESULT_W-1:0]        out_value_r, out_value_nxt;
  logic [IDX_W-1:0]           out_seg_r, out_seg_nxt;
  logic                       out_sat_r, out_sat_nxt;

  logic                       in_xfer;
  logic                       load_we;
  logic [IDX_W-1:0]           rd_addr;
  logic [COORD_W-1:0]         knot_rd;
  logic [COEF_W-1:0]          coef_rd;
  logic [COEF_W-1:0]          coef_wdata;
  logic [CNT_W-1:0]           n_knots;
  logic [IDX_W-1:0]           last_idx;

  // search and datapath temporaries
  logic signed [COORD_W-1:0]  knot_s;
  logic                       gt;
  logic [IDX_W-1:0]           lo_s, up_s;
  logic [IDX_W:0]             mid_sum;
  logic signed [VALUE_W-1:0]  ca, cb, cc, cd;
  sat_t                       sat_d3, sat_d6, sat_c2, sat_rnd, sat_add, sat_fin;

  // handshake
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign load_we   = in_xfer && (in_tuser == OP_LOAD);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_seg_r, out_value_r};
  assign out_tuser  = out_sat_r;

  // knot count clamped to the table range
  always_comb begin
    if (knot_count_r < CNT_W'(MIN_KNOTS)) begin
      n_knots = CNT_W'(MIN_KNOTS);
    end else if (knot_count_r > CNT_W'(MAX_KNOTS)) begin
      n_knots = CNT_W'(MAX_KNOTS);
    end else begin
      n_knots = knot_count_r;
    end
  end
  assign last_idx = IDX_W'(n_knots - CNT_W'(ONE_MUL));

  assign coef_wdata = {in_tdata[IN_D_LSB +: VALUE_W], in_tdata[IN_C_LSB +: VALUE_W],
                       in_tdata[IN_B_LSB +: VALUE_W], in_tdata[IN_A_LSB +: VALUE_W]};

  // knot abscissa ram
  cspl_ram #(
    .WIDTH (COORD_W),
    .DEPTH (MAX_KNOTS)
  ) u_knot_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_tdata[IN_IDX_LSB +: IDX_W]),
    .wdata (in_tdata[IN_KNOT_LSB +: COORD_W]),
    .raddr (rd_addr),
    .rdata (knot_rd)
  );

  // segment coefficient ram, {d, c, b, a}
  cspl_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_KNOTS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_tdata[IN_IDX_LSB +: IDX_W]),
    .wdata (coef_wdata),
    .raddr (rd_addr),
    .rdata (coef_rd)
  );

  assign knot_s = $signed(knot_rd);
  assign ca     = $signed(coef_rd[0 * VALUE_W +: VALUE_W]);
  assign cb     = $signed(coef_rd[1 * VALUE_W +: VALUE_W]);
  assign cc     = $signed(coef_rd[2 * VALUE_W +: VALUE_W]);
  assign cd     = $signed(coef_rd[3 * VALUE_W +: VALUE_W]);

  // binary search step on the knot just read
  always_comb begin
    gt      = q_r > knot_s;
    lo_s    = gt ? mid_r : lo_r;
    up_s    = gt ? up_r : mid_r;
    mid_sum = {1'b0, lo_s} + {1'b0, up_s};
  end

  // constant multiples and step saturation
  always_comb begin
    sat_d3  = sat_to(widen(cd) * WIDE_W'(D1_D_MUL), VALUE_W);
    sat_d6  = sat_to(widen(cd) * WIDE_W'(D2_D_MUL), VALUE_W);
    sat_c2  = sat_to(widen(cc) * WIDE_W'(D1_C_MUL), VALUE_W);
    sat_rnd = sat_to(round_q(prod_r), VALUE_W);
    sat_add = sat_to(widen(rnd_r) + widen(add0_r), VALUE_W);
    sat_fin = sat_to(widen(t_r), RESULT_W);
  end

  // sequencer: read, search, evaluate
  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    deriv_nxt     = deriv_r;
    k0_nxt        = k0_r;
    lo_nxt        = lo_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    seg_nxt       = seg_r;
    h_nxt         = h_r;
    t_nxt         = t_r;
    add0_nxt      = add0_r;
    add1_nxt      = add1_r;
    add2_nxt      = add2_r;
    rounds_nxt    = rounds_r;
    prod_nxt      = prod_r;
    rnd_nxt       = rnd_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_seg_nxt   = out_seg_r;
    out_sat_nxt   = out_sat_r;
    rd_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        // knot 0 is read here, ready in S_FIRST
        rd_addr = '0;
        if (in_xfer && (in_tuser == OP_EVAL)) begin
          q_nxt     = $signed(in_tdata[IN_Q_LSB +: COORD_W]);
          deriv_nxt = deriv_t'(in_tdata[IN_DRV_LSB +: DRV_W]);
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        k0_nxt    = knot_s;
        rd_addr   = last_idx;
        state_nxt = S_LAST;
      end
      S_LAST: begin
        if ((q_r >= k0_r) && (q_r <= knot_s)) begin
          lo_nxt    = '0;
          up_nxt    = last_idx;
          mid_nxt   = last_idx >> 1;
          rd_addr   = last_idx >> 1;
          state_nxt = S_SEARCH;
        end else if (q_r > knot_s) begin
          seg_nxt   = last_idx - IDX_W'(ONE_MUL);
          rd_addr   = last_idx - IDX_W'(ONE_MUL);
          state_nxt = S_COEF;
        end else begin
          seg_nxt   = '0;
          rd_addr   = '0;
          state_nxt = S_COEF;
        end
      end
      S_SEARCH: begin
        lo_nxt = lo_s;
        up_nxt = up_s;
        if ((up_s - lo_s) > IDX_W'(ONE_MUL)) begin
          mid_nxt = mid_sum[IDX_W:1];
          rd_addr = mid_sum[IDX_W:1];
        end else begin
          rd_addr   = up_s;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        // knot at the upper bound decides between the two
        seg_nxt   = gt ? up_r : lo_r;
        rd_addr   = gt ? up_r : lo_r;
        lo_nxt    = lo_r;
        state_nxt = S_COEF;
      end
      S_COEF: begin
        h_nxt = $signed({q_r[COORD_W-1], q_r}) - $signed({knot_s[COORD_W-1], knot_s});
        case (deriv_r)
          DRV_VALUE: begin
            t_nxt      = cd;
            add0_nxt   = cc;
            add1_nxt   = cb;
            add2_nxt   = ca;
            rounds_nxt = 2'd3;
            clip_nxt   = 1'b0;
          end
          DRV_FIRST: begin
            t_nxt      = sat_d3.val[VALUE_W-1:0];
            add0_nxt   = sat_c2.val[VALUE_W-1:0];
            add1_nxt   = cb;
            rounds_nxt = 2'd2;
            clip_nxt   = sat_d3.clip | sat_c2.clip;
          end
          DRV_SECOND: begin
            t_nxt      = sat_d6.val[VALUE_W-1:0];
            add0_nxt   = sat_c2.val[VALUE_W-1:0];
            rounds_nxt = 2'd1;
            clip_nxt   = sat_d6.clip | sat_c2.clip;
          end
          default: begin
            t_nxt      = '0;
            rounds_nxt = 2'd0;
            clip_nxt   = 1'b0;
          end
        endcase
        state_nxt = (rounds_nxt == 2'd0) ? S_DONE : S_MUL;
      end
      S_MUL: begin
        prod_nxt  = t_r * h_r;
        state_nxt = S_RND;
      end
      S_RND: begin
        rnd_nxt   = sat_rnd.val[VALUE_W-1:0];
        clip_nxt  = clip_r | sat_rnd.clip;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        t_nxt      = sat_add.val[VALUE_W-1:0];
        clip_nxt   = clip_r | sat_add.clip;
        add0_nxt   = add1_r;
        add1_nxt   = add2_r;
        rounds_nxt = rounds_r - 2'd1;
        state_nxt  = (rounds_r == 2'd1) ? S_DONE : S_MUL;
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = sat_fin.val[RESULT_W-1:0];
          out_seg_nxt   = seg_r;
          out_sat_nxt   = clip_r | sat_fin.clip;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      knot_count_r <= CNT_W'(CNT_RESET);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        knot_count_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    deriv_r     <= deriv_nxt;
    k0_r        <= k0_nxt;
    lo_r        <= lo_nxt;
    up_r        <= up_nxt;
    mid_r       <= mid_nxt;
    seg_r       <= seg_nxt;
    h_r         <= h_nxt;
    t_r         <= t_nxt;
    add0_r      <= add0_nxt;
    add1_r      <= add1_nxt;
    add2_r      <= add2_nxt;
    rounds_r    <= rounds_nxt;
    prod_r      <= prod_nxt;
    rnd_r       <= rnd_nxt;
    clip_r      <= clip_nxt;
    out_value_r <= out_value_nxt;
    out_seg_r   <= out_seg_nxt;
    out_sat_r   <= out_sat_nxt;
  end

endmodule
